// File: src/ddo_pkg.sv
// ddo_pkg: shared constants, step codes, command and status types for the odometry block
// no dependencies; used by every module of the block but ddo_mul, by scoped names
`default_nettype none
package ddo_pkg;

	localparam int TRIG_ITERATIONS = 16;
	localparam int POS_FRAC_BITS   = 16;

	localparam int MUL_W    = 64;
	localparam int DIV_N_W  = 80;
	localparam int DIV_D_W  = 62;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);
	localparam int TRIG_W   = 34;
	localparam int CNT_W    = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;

	localparam logic [5:0]  DIST_SHIFT = 6'(48 - POS_FRAC_BITS);
	localparam logic [5:0]  TRIG_SHIFT = 6'd30;
	localparam logic [63:0] PI_OVER_360_Q40 = 64'd9595049035;
	localparam logic [63:0] INV_PI_Q30      = 64'd341782638;
	localparam logic [TRIG_W-1:0] CORDIC_START = TRIG_W'(652032874);

	localparam logic [1:0] OP_SAMPLE   = 2'd0;
	localparam logic [1:0] OP_SET_POS  = 2'd1;
	localparam logic [1:0] OP_SET_POSE = 2'd2;
	localparam logic [1:0] OP_NONE     = 2'd3;

	localparam logic [1:0] CFG_WHEEL_RADIUS = 2'd0;
	localparam logic [1:0] CFG_HALF_TRACK   = 2'd1;
	localparam logic [1:0] CFG_TURN_LIMIT   = 2'd2;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_M_SUM  = 4'd1;
	localparam logic [3:0] ST_M_DIST = 4'd2;
	localparam logic [3:0] ST_M_NUM  = 4'd3;
	localparam logic [3:0] ST_DIV_T  = 4'd4;
	localparam logic [3:0] ST_SEL    = 4'd5;
	localparam logic [3:0] ST_COR_H  = 4'd6;
	localparam logic [3:0] ST_DIV_G  = 4'd7;
	localparam logic [3:0] ST_M_G    = 4'd8;
	localparam logic [3:0] ST_M_LEN  = 4'd9;
	localparam logic [3:0] ST_COR_D  = 4'd10;
	localparam logic [3:0] ST_M_X    = 4'd11;
	localparam logic [3:0] ST_M_Y    = 4'd12;
	localparam logic [3:0] ST_FIN    = 4'd13;

	typedef struct packed {
		logic       accept;
		logic       mul_start;
		logic       div_start;
		logic       cor_start;
		logic       capture;
		logic       out_load;
		logic [3:0] step;
	} ddo_cmd_t;

	typedef struct packed {
		logic       mul_done;
		logic       div_done;
		logic       cor_done;
		logic       straight;
		logic [1:0] op;
	} ddo_stat_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051D;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2E;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9;
			5'd15: v = 32'h0000517C;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A2F;
			5'd19: v = 32'h00000517;
			5'd20: v = 32'h0000028B;
			5'd21: v = 32'h00000145;
			5'd22: v = 32'h000000A2;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000028;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000002;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: src/ddo_mul.sv
// ddo_mul: sequential signed 64x64 multiply, shift right with rounding half away from zero
// four 32x32 partial products, one per cycle; does not use ddo_pkg
`default_nettype none
module ddo_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	input  wire logic [5:0]  shift,
	output logic [63:0]      result,
	output logic             done
);
	logic [63:0]  ua_q, ub_q, res_q;
	logic         neg_q, busy_q, done_q;
	logic [5:0]   sh_q;
	logic [127:0] acc_q;
	logic [2:0]   ph_q;
	logic [31:0]  a_half, b_half;
	logic [63:0]  pp, mag;
	logic [127:0] pp_sh, rnd, shifted;

	always_comb begin
		a_half = ph_q[1] ? ua_q[63:32] : ua_q[31:0];
		b_half = ph_q[0] ? ub_q[63:32] : ub_q[31:0];
		pp = a_half * b_half;
		case (ph_q[1:0])
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		rnd = (sh_q == 6'd0) ? 128'd0 : (128'd1 << (sh_q - 6'd1));
		shifted = acc_q >> sh_q;
		mag = shifted[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= 3'd0;
			end else if (busy_q) begin
				ph_q <= ph_q + 3'd1;
				if (ph_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= a[63] ? (~a + 64'd1) : a;
			ub_q  <= b[63] ? (~b + 64'd1) : b;
			neg_q <= a[63] ^ b[63];
			sh_q  <= shift;
			acc_q <= 128'd0;
		end else if (busy_q) begin
			case (ph_q)
				3'd0, 3'd1, 3'd2, 3'd3: acc_q <= acc_q + pp_sh;
				3'd4:    acc_q <= acc_q + rnd;
				3'd5:    res_q <= neg_q ? (~mag + 64'd1) : mag;
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign result = res_q;
	assign done   = done_q;
endmodule
`default_nettype wire

// File: src/ddo_div.sv
// ddo_div: unsigned restoring divider, one quotient bit per cycle
// dividend and divisor widths from ddo_pkg
`default_nettype none
module ddo_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ddo_pkg::DIV_N_W-1:0]   dividend,
	input  wire logic [ddo_pkg::DIV_D_W-1:0]   divisor,
	output logic [ddo_pkg::DIV_N_W-1:0]        quotient,
	output logic                               done
);
	logic [ddo_pkg::DIV_N_W-1:0]   quo_q;
	logic [ddo_pkg::DIV_D_W-1:0]   rem_q, dv_q;
	logic [ddo_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q, done_q;
	logic [ddo_pkg::DIV_D_W:0]     trial;
	logic [ddo_pkg::DIV_D_W+1:0]   diff;
	logic                          ge;

	always_comb begin
		trial = {rem_q, quo_q[ddo_pkg::DIV_N_W-1]};
		diff  = {1'b0, trial} - {2'b00, dv_q};
		ge    = !diff[ddo_pkg::DIV_D_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ddo_pkg::DIV_CNT_W'(ddo_pkg::DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ddo_pkg::DIV_N_W-2:0], ge};
			rem_q <= ge ? diff[ddo_pkg::DIV_D_W-1:0] : trial[ddo_pkg::DIV_D_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule
`default_nettype wire

// File: src/ddo_cordic.sv
// ddo_cordic: rotation-mode cordic, cosine and sine of a binary angle in Q.30
// one micro-rotation per cycle after quadrant folding; uses ddo_pkg
`default_nettype none
module ddo_cordic (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [31:0]                 angle,
	output logic [ddo_pkg::TRIG_W-1:0]       cos_out,
	output logic [ddo_pkg::TRIG_W-1:0]       sin_out,
	output logic                             done
);
	logic signed [ddo_pkg::TRIG_W-1:0] x_q, y_q, z_q, dx, dy, at;
	logic [1:0]                        quad, quad_q;
	logic [31:0]                       zr, shifted_ang;
	logic [ddo_pkg::CNT_W-1:0]         cnt_q;
	logic                              busy_q, done_q;

	always_comb begin
		shifted_ang = angle + 32'h40000000;
		quad = shifted_ang[31:30];
		zr   = angle - {quad, 30'd0};
		dx   = y_q >>> cnt_q;
		dy   = x_q >>> cnt_q;
		at   = {2'b00, ddo_pkg::atan_bam(5'(cnt_q))};
		case (quad_q)
			2'd0: begin
				cos_out = x_q;
				sin_out = y_q;
			end
			2'd1: begin
				cos_out = -y_q;
				sin_out = x_q;
			end
			2'd2: begin
				cos_out = -x_q;
				sin_out = -y_q;
			end
			default: begin
				cos_out = y_q;
				sin_out = -x_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ddo_pkg::CNT_W'(ddo_pkg::TRIG_ITERATIONS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= ddo_pkg::CORDIC_START;
			y_q    <= '0;
			z_q    <= {{2{zr[31]}}, zr};
			quad_q <= quad;
		end else if (busy_q) begin
			if (!z_q[ddo_pkg::TRIG_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
endmodule
`default_nettype wire

// File: src/ddo_dp.sv
// ddo_dp: odometry datapath with pose, encoder history, settings and arithmetic units
// instantiates ddo_mul, ddo_div, ddo_cordic; uses ddo_pkg
`default_nettype none
module ddo_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ddo_pkg::ddo_cmd_t cmd,
	output ddo_pkg::ddo_stat_t     stat,
	input  wire logic [1:0]        op,
	input  wire logic [31:0]       left_angle,
	input  wire logic [31:0]       right_angle,
	input  wire logic [47:0]       set_x,
	input  wire logic [47:0]       set_y,
	input  wire logic [31:0]       set_heading,
	input  wire logic              cfg_valid,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [19:0]       cfg_data,
	output logic [47:0]            pos_x_out,
	output logic [47:0]            pos_y_out,
	output logic [31:0]            heading_out
);
	localparam logic [79:0] QSAT = 80'd1 << 61;
	localparam logic [62:0] TSAT = 63'd1 << 61;

	logic [15:0] wr_q, ht_q, ht_eff;
	logic [19:0] lim_q;
	logic [31:0] prev_l_q, prev_r_q, dl_q, dr_q, head_q, frac_q, half_q;
	logic [47:0] pos_x_q, pos_y_q, px_out_q, py_out_q;
	logic [31:0] hd_out_q;
	logic [63:0] a_q, dist_q, g_q, len_q, num_mag, len_sel, r64;
	logic [62:0] turn_q, turn_abs;
	logic [ddo_pkg::TRIG_W-1:0] hs_q, ca_q, sa_q, hs_mag;
	logic [32:0] sum33, dif33;
	logic [25:0] den;

	logic [63:0] mul_a, mul_b, mul_res;
	logic [5:0]  mul_sh;
	logic        mul_done;
	logic [ddo_pkg::DIV_N_W-1:0] div_n, quo, tf;
	logic [ddo_pkg::DIV_D_W-1:0] div_d;
	logic        div_done;
	logic [31:0] cor_ang;
	logic [ddo_pkg::TRIG_W-1:0] cor_c, cor_s;
	logic        cor_done;
	logic        num_neg, straight, gneg, sat_pos, sat_neg;
	logic [62:0] turn_w;
	logic [63:0] g_w;

	always_comb begin
		r64     = {48'd0, wr_q};
		ht_eff  = (ht_q == 16'd0) ? 16'd1 : ht_q;
		den     = 26'(ht_eff) * 26'd720;
		sum33   = {dl_q[31], dl_q} + {dr_q[31], dr_q};
		dif33   = {dr_q[31], dr_q} - {dl_q[31], dl_q};
		num_neg = a_q[63];
		num_mag = num_neg ? (~a_q + 64'd1) : a_q;
		turn_abs = turn_q[62] ? (~turn_q + 63'd1) : turn_q;
		straight = (turn_q == 63'd0) || (turn_abs < {43'd0, lim_q});
		len_sel  = straight ? dist_q : len_q;
		hs_mag   = hs_q[ddo_pkg::TRIG_W-1] ? -hs_q : hs_q;

		tf      = num_neg ? (~quo + 80'd1) : quo;
		sat_pos = !num_neg && (quo >= QSAT);
		sat_neg = num_neg && (quo > QSAT);
		turn_w  = sat_pos ? TSAT : (sat_neg ? (~TSAT + 63'd1) : tf[62:0]);
		gneg    = hs_q[ddo_pkg::TRIG_W-1] ^ turn_q[62];
		g_w     = gneg ? (~quo[63:0] + 64'd1) : quo[63:0];

		mul_a  = '0;
		mul_b  = '0;
		mul_sh = ddo_pkg::TRIG_SHIFT;
		unique case (cmd.step)
			ddo_pkg::ST_M_SUM: begin
				mul_a  = r64;
				mul_b  = {{31{sum33[32]}}, sum33};
				mul_sh = 6'd0;
			end
			ddo_pkg::ST_M_DIST: begin
				mul_a  = a_q;
				mul_b  = ddo_pkg::PI_OVER_360_Q40;
				mul_sh = ddo_pkg::DIST_SHIFT;
			end
			ddo_pkg::ST_M_NUM: begin
				mul_a  = r64;
				mul_b  = {{31{dif33[32]}}, dif33};
				mul_sh = 6'd0;
			end
			ddo_pkg::ST_M_G: begin
				mul_a = g_q;
				mul_b = ddo_pkg::INV_PI_Q30;
			end
			ddo_pkg::ST_M_LEN: begin
				mul_a = dist_q;
				mul_b = g_q;
			end
			ddo_pkg::ST_M_X: begin
				mul_a = len_sel;
				mul_b = {{(64-ddo_pkg::TRIG_W){ca_q[ddo_pkg::TRIG_W-1]}}, ca_q};
			end
			ddo_pkg::ST_M_Y: begin
				mul_a = len_sel;
				mul_b = {{(64-ddo_pkg::TRIG_W){sa_q[ddo_pkg::TRIG_W-1]}}, sa_q};
			end
			default: begin
				mul_a = '0;
			end
		endcase

		if (cmd.step == ddo_pkg::ST_DIV_G) begin
			div_n = {16'd0, hs_mag[31:0], 32'd0};
			div_d = turn_abs[61:0];
		end else begin
			div_n = {num_mag[47:0], (num_neg ? {6'd0, den - 26'd1} : 32'd0)};
			div_d = {36'd0, den};
		end

		cor_ang = (cmd.step == ddo_pkg::ST_COR_H) ? half_q
			: head_q + (straight ? frac_q : half_q);
	end

	ddo_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.mul_start),
		.a(mul_a), .b(mul_b), .shift(mul_sh),
		.result(mul_res), .done(mul_done)
	);

	ddo_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(div_n), .divisor(div_d),
		.quotient(quo), .done(div_done)
	);

	ddo_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cmd.cor_start),
		.angle(cor_ang), .cos_out(cor_c), .sin_out(cor_s), .done(cor_done)
	);

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= 16'd10240;
			ht_q     <= 16'd20480;
			lim_q    <= 20'd68719;
			prev_l_q <= '0;
			prev_r_q <= '0;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			head_q   <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ddo_pkg::CFG_WHEEL_RADIUS: wr_q  <= cfg_data[15:0];
					ddo_pkg::CFG_HALF_TRACK:   ht_q  <= cfg_data[15:0];
					ddo_pkg::CFG_TURN_LIMIT:   lim_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				case (op)
					ddo_pkg::OP_SAMPLE: begin
						prev_l_q <= left_angle;
						prev_r_q <= right_angle;
					end
					ddo_pkg::OP_SET_POS: begin
						pos_x_q <= set_x;
						pos_y_q <= set_y;
					end
					ddo_pkg::OP_SET_POSE: begin
						pos_x_q <= set_x;
						pos_y_q <= set_y;
						head_q  <= set_heading;
					end
					default: ;
				endcase
			end
			if (cmd.capture) begin
				case (cmd.step)
					ddo_pkg::ST_M_X: pos_x_q <= pos_x_q + mul_res[47:0];
					ddo_pkg::ST_M_Y: begin
						pos_y_q <= pos_y_q + mul_res[47:0];
						head_q  <= head_q + frac_q;
					end
					default: ;
				endcase
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dl_q <= left_angle - prev_l_q;
			dr_q <= right_angle - prev_r_q;
		end
		if (cmd.capture) begin
			case (cmd.step)
				ddo_pkg::ST_M_SUM:  a_q <= mul_res;
				ddo_pkg::ST_M_DIST: dist_q <= mul_res;
				ddo_pkg::ST_M_NUM:  a_q <= mul_res;
				ddo_pkg::ST_DIV_T: begin
					turn_q <= turn_w;
					frac_q <= tf[31:0];
					half_q <= tf[32:1];
				end
				ddo_pkg::ST_COR_H:  hs_q <= cor_s;
				ddo_pkg::ST_DIV_G:  g_q <= g_w;
				ddo_pkg::ST_M_G:    g_q <= mul_res;
				ddo_pkg::ST_M_LEN:  len_q <= mul_res;
				ddo_pkg::ST_COR_D: begin
					ca_q <= cor_c;
					sa_q <= cor_s;
				end
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			px_out_q <= pos_x_q;
			py_out_q <= pos_y_q;
			hd_out_q <= head_q;
		end
	end

	always_comb begin
		stat.mul_done = mul_done;
		stat.div_done = div_done;
		stat.cor_done = cor_done;
		stat.straight = straight;
		stat.op       = op;
	end

	assign pos_x_out   = px_out_q;
	assign pos_y_out   = py_out_q;
	assign heading_out = hd_out_q;
endmodule
`default_nettype wire

// File: src/ddo_ctrl.sv
// ddo_ctrl: sequencer for the odometry update and the request handshakes
// drives ddo_dp through ddo_pkg::ddo_cmd_t and reads ddo_pkg::ddo_stat_t
`default_nettype none
module ddo_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire ddo_pkg::ddo_stat_t stat,
	output ddo_pkg::ddo_cmd_t       cmd
);
	logic [3:0] state_q, state_d;
	logic       launched_q, out_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.step = state_q;
		state_d  = state_q;
		unique case (state_q) inside
			ddo_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = (stat.op == ddo_pkg::OP_SAMPLE) ? ddo_pkg::ST_M_SUM
						: ddo_pkg::ST_FIN;
				end
			end
			ddo_pkg::ST_M_SUM, ddo_pkg::ST_M_DIST, ddo_pkg::ST_M_NUM, ddo_pkg::ST_M_G,
			ddo_pkg::ST_M_LEN, ddo_pkg::ST_M_X, ddo_pkg::ST_M_Y: begin
				cmd.mul_start = !launched_q;
				cmd.capture   = stat.mul_done;
				if (stat.mul_done) begin
					case (state_q)
						ddo_pkg::ST_M_SUM:  state_d = ddo_pkg::ST_M_DIST;
						ddo_pkg::ST_M_DIST: state_d = ddo_pkg::ST_M_NUM;
						ddo_pkg::ST_M_NUM:  state_d = ddo_pkg::ST_DIV_T;
						ddo_pkg::ST_M_G:    state_d = ddo_pkg::ST_M_LEN;
						ddo_pkg::ST_M_LEN:  state_d = ddo_pkg::ST_COR_D;
						ddo_pkg::ST_M_X:    state_d = ddo_pkg::ST_M_Y;
						default:            state_d = ddo_pkg::ST_FIN;
					endcase
				end
			end
			ddo_pkg::ST_DIV_T, ddo_pkg::ST_DIV_G: begin
				cmd.div_start = !launched_q;
				cmd.capture   = stat.div_done;
				if (stat.div_done) begin
					state_d = (state_q == ddo_pkg::ST_DIV_T) ? ddo_pkg::ST_SEL
						: ddo_pkg::ST_M_G;
				end
			end
			ddo_pkg::ST_SEL: begin
				state_d = stat.straight ? ddo_pkg::ST_COR_D : ddo_pkg::ST_COR_H;
			end
			ddo_pkg::ST_COR_H, ddo_pkg::ST_COR_D: begin
				cmd.cor_start = !launched_q;
				cmd.capture   = stat.cor_done;
				if (stat.cor_done) begin
					state_d = (state_q == ddo_pkg::ST_COR_H) ? ddo_pkg::ST_DIV_G
						: ddo_pkg::ST_M_X;
				end
			end
			ddo_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ddo_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ddo_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ddo_pkg::ST_IDLE;
			launched_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture)
				launched_q <= 1'b0;
			else if (cmd.mul_start || cmd.div_start || cmd.cor_start)
				launched_q <= 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ddo_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// File: src/differential_drive_odometry.sv
// differential_drive_odometry: top level of the wheel odometry block
// joins ddo_ctrl and ddo_dp; uses ddo_pkg
//
//  channel | signals                                         | direction
//  in      | in_valid in_ready op left_angle right_angle     | request in
//          | set_x set_y set_heading                         |
//  out     | out_valid out_ready pos_x_out pos_y_out          | request out
//          | heading_out                                     |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data          | register write in
//
// correction requests go from idle straight to the output stage; an encoder sample runs the
// 80-step shift-subtract divider once on a straight step and twice on an arc
// one request at a time; the next is taken while the last result waits at the output
// reset restores the default settings and clears pose and encoder history
// a stalled output holds the finished request until out_ready
`default_nettype none
module differential_drive_odometry (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] left_angle,
	input  wire logic [31:0] right_angle,
	input  wire logic [47:0] set_x,
	input  wire logic [47:0] set_y,
	input  wire logic [31:0] set_heading,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [47:0]      pos_x_out,
	output logic [47:0]      pos_y_out,
	output logic [31:0]      heading_out,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data
);
	ddo_pkg::ddo_cmd_t  cmd;
	ddo_pkg::ddo_stat_t stat;

	assign cfg_ready = 1'b1;

	ddo_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	ddo_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.op(op), .left_angle(left_angle), .right_angle(right_angle),
		.set_x(set_x), .set_y(set_y), .set_heading(set_heading),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pos_x_out(pos_x_out), .pos_y_out(pos_y_out), .heading_out(heading_out)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while the previous one is in progress");

	a_one_unit_done: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({stat.mul_done, stat.div_done, stat.cor_done}))
		else $error("two arithmetic units finished together");

	a_result_ends_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown before the sequencer returned to idle");

	a_capture_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (stat.mul_done || stat.div_done || stat.cor_done))
		else $error("capture without a finished unit");
endmodule
`default_nettype wire
